>>> hw/rtl/pse_pkg.sv
`default_nettype none

package pse_pkg;

    // store geometry
    localparam int MAX_EXP = 16;
    localparam int AW      = MAX_EXP;             // mark store address width
    localparam int VW      = AW + 1;              // walk index, holds j + i
    localparam int CW      = (AW > 16) ? AW : 16; // query compare width
    localparam int DEPTH   = 1 << AW;
    localparam int EXP_W   = 5;

    localparam logic [EXP_W-1:0] EXP_MIN   = EXP_W'(3);
    localparam logic [EXP_W-1:0] EXP_MAX   = EXP_W'(MAX_EXP);
    localparam logic [EXP_W-1:0] EXP_RESET = EXP_W'(16);
    localparam logic [AW-1:0]    FIRST_PRIME = AW'(2);

    // commands
    localparam logic CMD_RUN   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // step counter
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] ST_DISP  = 4'd1;
    localparam logic [PC_W-1:0] ST_RINIT = 4'd2;
    localparam logic [PC_W-1:0] ST_CLEAR = 4'd3;
    localparam logic [PC_W-1:0] ST_IINIT = 4'd4;
    localparam logic [PC_W-1:0] ST_CHECK = 4'd5;
    localparam logic [PC_W-1:0] ST_COUNT = 4'd6;
    localparam logic [PC_W-1:0] ST_MARK  = 4'd7;
    localparam logic [PC_W-1:0] ST_NEXT  = 4'd8;
    localparam logic [PC_W-1:0] ST_FIN   = 4'd9;
    localparam logic [PC_W-1:0] ST_QRY   = 4'd10;
    localparam logic [PC_W-1:0] ST_QRES  = 4'd11;
    localparam logic [PC_W-1:0] ST_LAST  = ST_QRES;

    // candidate register ops
    localparam logic [1:0] I_KEEP = 2'd0;
    localparam logic [1:0] I_TWO  = 2'd1;
    localparam logic [1:0] I_INC  = 2'd2;

    // walk register ops
    localparam logic [2:0] J_KEEP = 3'd0;
    localparam logic [2:0] J_ZERO = 3'd1;
    localparam logic [2:0] J_INC  = 3'd2;
    localparam logic [2:0] J_DBL  = 3'd3;
    localparam logic [2:0] J_ADD  = 3'd4;

    // store write ops
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_ZERO = 2'd1;
    localparam logic [1:0] WR_ONE  = 2'd2;

    // jump conditions
    localparam logic [3:0] C_NEVER     = 4'd0;
    localparam logic [3:0] C_ALWAYS    = 4'd1;
    localparam logic [3:0] C_NO_START  = 4'd2;
    localparam logic [3:0] C_QUERY     = 4'd3;
    localparam logic [3:0] C_J1_LT_LIM = 4'd4;
    localparam logic [3:0] C_MARKED    = 4'd5;
    localparam logic [3:0] C_I2_GE_LIM = 4'd6;
    localparam logic [3:0] C_JI_LT_LIM = 4'd7;
    localparam logic [3:0] C_I1_LT_LIM = 4'd8;

    typedef struct packed {
        logic [1:0]      i_op;
        logic [2:0]      j_op;
        logic [1:0]      wr_op;
        logic            rd_num;
        logic            cnt_clr;
        logic            cnt_inc;
        logic            lim_load;
        logic            fin;
        logic            qres;
        logic [3:0]      cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    // control program
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '0;
        case (pc)
            ST_IDLE:
            begin
                w.cond   = C_NO_START;
                w.target = ST_IDLE;
            end
            ST_DISP:
            begin
                w.cond   = C_QUERY;
                w.target = ST_QRY;
            end
            ST_RINIT:
            begin
                w.lim_load = 1'b1;
                w.j_op     = J_ZERO;
                w.cnt_clr  = 1'b1;
            end
            ST_CLEAR:
            begin
                w.wr_op  = WR_ZERO;
                w.j_op   = J_INC;
                w.cond   = C_J1_LT_LIM;
                w.target = ST_CLEAR;
            end
            ST_IINIT:
            begin
                w.i_op = I_TWO;
            end
            ST_CHECK:
            begin
                w.cond   = C_MARKED;
                w.target = ST_NEXT;
            end
            ST_COUNT:
            begin
                w.cnt_inc = 1'b1;
                w.j_op    = J_DBL;
                w.cond    = C_I2_GE_LIM;
                w.target  = ST_NEXT;
            end
            ST_MARK:
            begin
                w.wr_op  = WR_ONE;
                w.j_op   = J_ADD;
                w.cond   = C_JI_LT_LIM;
                w.target = ST_MARK;
            end
            ST_NEXT:
            begin
                w.i_op   = I_INC;
                w.cond   = C_I1_LT_LIM;
                w.target = ST_CHECK;
            end
            ST_FIN:
            begin
                w.fin    = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
            ST_QRY:
            begin
                w.rd_num = 1'b1;
            end
            ST_QRES:
            begin
                w.qres   = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/prime_sieve_engine.sv
`default_nettype none

// channel   | direction | handshake              | word
// ----------+-----------+------------------------+------------------------------
// command   | in        | start high, busy low   | cmd, number
// result    | out       | done, one cycle        | prime_count, limit, is_prime,
//           |           |                        | status
// config    | in        | cfg_valid && cfg_ready | exponent
//
// a run clears the mark store below the limit, then for each candidate checks its
// mark, counts it if unmarked and marks its multiples from its double on; its
// length is set by the single write port of the store
// a query passes through dispatch, one store read and the answer step
// reset clears control state only; the mark store is cleared by each run
// the result strobe cannot be stalled; busy holds off commands while working

module prime_sieve_engine (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        cmd,
    input  wire logic [15:0]                 number,
    output logic                             done,
    output logic [15:0]                      prime_count,
    output logic [15:0]                      limit,
    output logic                             is_prime,
    output logic                             status,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [pse_pkg::EXP_W-1:0]   exponent
);

    // control state
    logic [pse_pkg::PC_W-1:0]  pc_reg, pc_next;
    logic [pse_pkg::EXP_W-1:0] exponent_reg;
    logic                      sieve_done_reg;
    logic                      done_reg;

    // datapath
    logic [pse_pkg::AW-1:0] i_reg, i_next;
    logic [pse_pkg::VW-1:0] j_reg, j_next;
    logic [pse_pkg::AW-1:0] cnt_reg, cnt_next;
    logic [pse_pkg::AW-1:0] lim_reg, lim_next;
    logic [pse_pkg::AW-1:0] stored_count_reg;
    logic [pse_pkg::AW-1:0] stored_limit_reg;
    logic                   cmd_reg;
    logic [15:0]            number_reg;

    // result words
    logic [15:0] prime_count_reg;
    logic [15:0] limit_reg;
    logic        is_prime_reg;
    logic        status_reg;

    // mark store
    logic                   mark_mem [0:pse_pkg::DEPTH-1];
    logic                   rd_data_reg;
    logic [pse_pkg::AW-1:0] rd_addr;
    logic                   wr_en;

    pse_pkg::ucode_t        uw;
    logic                   accept;
    logic                   jump;
    logic [pse_pkg::EXP_W-1:0] e_sat;
    logic [pse_pkg::VW-1:0] lim_ext;
    logic [pse_pkg::VW-1:0] j_inc;
    logic [pse_pkg::VW-1:0] j_add;
    logic [pse_pkg::VW-1:0] i_dbl;
    logic [pse_pkg::AW-1:0] i_inc;
    logic [pse_pkg::CW-1:0] num_cw;
    logic [pse_pkg::CW-1:0] slim_cw;
    logic                   q_prime;

    // control word fetch and handshakes
    assign uw        = pse_pkg::ucode_rom(pc_reg);
    assign busy      = (pc_reg != pse_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = !busy;

    // arithmetic helpers
    assign lim_ext = {1'b0, lim_reg};
    assign j_inc   = j_reg + pse_pkg::VW'(1);
    assign j_add   = j_reg + {1'b0, i_reg};
    assign i_dbl   = {i_reg, 1'b0};
    assign i_inc   = i_reg + pse_pkg::AW'(1);

    // saturated exponent and limit
    always_comb
    begin
        if (exponent_reg < pse_pkg::EXP_MIN)
            e_sat = pse_pkg::EXP_MIN;
        else if (exponent_reg > pse_pkg::EXP_MAX)
            e_sat = pse_pkg::EXP_MAX;
        else
            e_sat = exponent_reg;
        lim_next = {pse_pkg::AW{1'b1}} >> (pse_pkg::EXP_MAX - e_sat);
    end

    // jump condition
    always_comb
    begin
        case (uw.cond)
            pse_pkg::C_NEVER:     jump = 1'b0;
            pse_pkg::C_ALWAYS:    jump = 1'b1;
            pse_pkg::C_NO_START:  jump = !start;
            pse_pkg::C_QUERY:     jump = (cmd_reg == pse_pkg::CMD_QUERY);
            pse_pkg::C_J1_LT_LIM: jump = (j_inc < lim_ext);
            pse_pkg::C_MARKED:    jump = rd_data_reg;
            pse_pkg::C_I2_GE_LIM: jump = (i_dbl >= lim_ext);
            pse_pkg::C_JI_LT_LIM: jump = (j_add < lim_ext);
            pse_pkg::C_I1_LT_LIM: jump = (i_inc < lim_reg);
            default:              jump = 1'b0;
        endcase
        pc_next = jump ? uw.target : pc_reg + pse_pkg::PC_W'(1);
    end

    // datapath next values
    always_comb
    begin
        case (uw.i_op)
            pse_pkg::I_TWO: i_next = pse_pkg::FIRST_PRIME;
            pse_pkg::I_INC: i_next = i_inc;
            default:        i_next = i_reg;
        endcase
        case (uw.j_op)
            pse_pkg::J_ZERO: j_next = '0;
            pse_pkg::J_INC:  j_next = j_inc;
            pse_pkg::J_DBL:  j_next = i_dbl;
            pse_pkg::J_ADD:  j_next = j_add;
            default:         j_next = j_reg;
        endcase
        if (uw.cnt_clr)
            cnt_next = '0;
        else if (uw.cnt_inc)
            cnt_next = cnt_reg + pse_pkg::AW'(1);
        else
            cnt_next = cnt_reg;
    end

    // store addressing; the read follows the next candidate, or the query number
    assign rd_addr = uw.rd_num ? pse_pkg::AW'(number_reg) : i_next;
    assign wr_en   = (uw.wr_op != pse_pkg::WR_NONE);

    // query answer
    assign num_cw  = pse_pkg::CW'(number_reg);
    assign slim_cw = pse_pkg::CW'(stored_limit_reg);
    assign q_prime = sieve_done_reg && (num_cw >= pse_pkg::CW'(2))
                     && (num_cw < slim_cw) && !rd_data_reg;

    // mark store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mark_mem[j_reg[pse_pkg::AW-1:0]] <= (uw.wr_op == pse_pkg::WR_ONE);
        rd_data_reg <= mark_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= pse_pkg::ST_IDLE;
            exponent_reg     <= pse_pkg::EXP_RESET;
            sieve_done_reg   <= 1'b0;
            stored_count_reg <= '0;
            stored_limit_reg <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            done_reg <= uw.fin || uw.qres;
            if (cfg_valid && cfg_ready)
                exponent_reg <= exponent;
            if (uw.fin)
            begin
                sieve_done_reg   <= 1'b1;
                stored_count_reg <= cnt_reg;
                stored_limit_reg <= lim_reg;
            end
        end
    end

    // datapath and result registers
    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        cnt_reg <= cnt_next;
        if (uw.lim_load)
            lim_reg <= lim_next;
        if (accept)
        begin
            cmd_reg    <= cmd;
            number_reg <= number;
        end
        if (uw.fin)
        begin
            prime_count_reg <= 16'(cnt_reg);
            limit_reg       <= 16'(lim_reg);
            is_prime_reg    <= 1'b0;
            status_reg      <= 1'b0;
        end
        else if (uw.qres)
        begin
            prime_count_reg <= 16'(stored_count_reg);
            limit_reg       <= 16'(stored_limit_reg);
            is_prime_reg    <= q_prime;
            status_reg      <= !sieve_done_reg;
        end
    end

    assign done        = done_reg;
    assign prime_count = prime_count_reg;
    assign limit       = limit_reg;
    assign is_prime    = is_prime_reg;
    assign status      = status_reg;

`ifndef SYNTH
    // a result only follows the finish or query-answer step
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(pc_reg) == pse_pkg::ST_FIN || $past(pc_reg) == pse_pkg::ST_QRES))
        else $error("result strobe without a finishing step");

    // store writes stay below the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (j_reg < lim_ext))
        else $error("mark store write at or above the limit");

    // a candidate under test is inside the sieve range
    assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == pse_pkg::ST_CHECK) |-> (i_reg >= pse_pkg::FIRST_PRIME && i_reg < lim_reg))
        else $error("candidate out of range");

    // a run result never flags a prime or an error
    assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == pse_pkg::ST_FIN) |=> (done && !is_prime && !status))
        else $error("run result carries query flags");

    // the step counter stays inside the program
    assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= pse_pkg::ST_LAST)
        else $error("step counter left the program");
`endif

endmodule

`default_nettype wire

>>> bench/prime_sieve_engine_tb.sv
`timescale 1ns / 100ps

module prime_sieve_engine_tb;

    localparam int QUIET_LIMIT = 2000000;

    typedef struct packed {
        logic        op;
        logic [15:0] num;
    } sieve_cmd_t;

    typedef struct packed {
        logic [15:0] prime_count;
        logic [15:0] limit;
        logic        is_prime;
        logic        status;
    } sieve_word_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      cmd = 1'b0;
    logic [15:0]               number = 16'd0;
    logic                      done;
    logic [15:0]               prime_count;
    logic [15:0]               limit;
    logic                      is_prime;
    logic                      status;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [pse_pkg::EXP_W-1:0] cfg_exponent = pse_pkg::EXP_RESET;

    // pending commands and expected result words
    sieve_cmd_t  cmd_q [$];
    sieve_word_t sieve_words_q [$];

    int unsigned sent_cnt = 0;
    int unsigned taken_cnt = 0;
    int unsigned cfg_cnt = 0;
    int unsigned quiet_cycles = 0;
    int unsigned err_cnt = 0;
    bit          steady = 1'b0;

    // shadow copy of the sieve state
    bit                        mark_bits [pse_pkg::DEPTH];
    logic [pse_pkg::EXP_W-1:0] exp_shadow = pse_pkg::EXP_RESET;
    int unsigned               found_primes = 0;
    int unsigned               top_bound = 0;
    bit                        sieve_ready = 1'b0;

    prime_sieve_engine u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .number      (number),
        .done        (done),
        .prime_count (prime_count),
        .limit       (limit),
        .is_prime    (is_prime),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .exponent    (cfg_exponent)
    );

    always #1 clk = ~clk;

    // expected word for one accepted command, updates the shadow state
    function automatic sieve_word_t sieve_predict(input logic op, input logic [15:0] num);
        int unsigned e;
        int unsigned i;
        int unsigned j;
        sieve_word_t r;
        r = '0;
        if (op == pse_pkg::CMD_RUN)
        begin
            e = exp_shadow;
            if (e < pse_pkg::EXP_MIN)
                e = pse_pkg::EXP_MIN;
            if (e > pse_pkg::EXP_MAX)
                e = pse_pkg::EXP_MAX;
            top_bound = (1 << e) - 1;
            found_primes = 0;
            for (i = 0; i < top_bound; i++)
                mark_bits[i] = 1'b0;
            for (i = 2; i < top_bound; i++)
            begin
                if (!mark_bits[i])
                begin
                    found_primes++;
                    for (j = 2 * i; j < top_bound; j += i)
                        mark_bits[j] = 1'b1;
                end
            end
            sieve_ready = 1'b1;
        end
        else if (!sieve_ready)
            r.status = 1'b1;
        else if (num >= 2 && num < top_bound && !mark_bits[num])
            r.is_prime = 1'b1;
        r.prime_count = 16'(found_primes);
        r.limit       = 16'(top_bound);
        return r;
    endfunction

    task automatic push_cmd(input logic op, input logic [15:0] num);
        sieve_cmd_t c;
        c.op  = op;
        c.num = num;
        cmd_q.push_back(c);
    endtask

    // wait until every queued command has been answered
    task automatic drain();
        while (cmd_q.size() != 0 || sent_cnt != taken_cnt || sieve_words_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_exponent(input logic [pse_pkg::EXP_W-1:0] v);
        int unsigned n0;
        n0 = cfg_cnt;
        if ($urandom_range(0, 99) < 16)
            repeat ($urandom_range(1, 4)) @(negedge clk);
        @(negedge clk);
        cfg_valid    <= 1'b1;
        cfg_exponent <= v;
        while (cfg_cnt == n0)
            @(negedge clk);
        cfg_valid    <= 1'b0;
        cfg_exponent <= pse_pkg::EXP_W'($urandom);
    endtask

    // command driver, one word held until start meets busy low
    always @(negedge clk)
    begin : cmd_drive
        sieve_cmd_t nxt;
        if (!rst_n)
            start <= 1'b0;
        else if (sent_cnt == taken_cnt)
        begin
            if (cmd_q.size() != 0 && (steady || $urandom_range(0, 99) >= 16))
            begin
                nxt = cmd_q.pop_front();
                start    <= 1'b1;
                cmd      <= nxt.op;
                number   <= nxt.num;
                sent_cnt <= sent_cnt + 1;
            end
            else
            begin
                start  <= 1'b0;
                cmd    <= 1'($urandom);
                number <= 16'($urandom);
            end
        end
    end

    // accept, predict, check and watchdog
    always @(posedge clk)
    begin : word_check
        sieve_word_t want;
        bit          moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (done)
            begin
                moved = 1'b1;
                if (sieve_words_q.size() == 0)
                begin
                    $error("result word with none expected");
                    err_cnt++;
                end
                else
                begin
                    want = sieve_words_q.pop_front();
                    if (prime_count !== want.prime_count)
                    begin
                        $error("prime_count: expected %0d, got %0d", want.prime_count,
                               prime_count);
                        err_cnt++;
                    end
                    if (limit !== want.limit)
                    begin
                        $error("limit: expected %0d, got %0d", want.limit, limit);
                        err_cnt++;
                    end
                    if (is_prime !== want.is_prime)
                    begin
                        $error("is_prime: expected %0d, got %0d", want.is_prime, is_prime);
                        err_cnt++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        err_cnt++;
                    end
                end
            end
            if (start && !busy)
            begin
                moved = 1'b1;
                sieve_words_q.push_back(sieve_predict(cmd, number));
                taken_cnt <= taken_cnt + 1;
            end
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                exp_shadow = cfg_exponent;
                cfg_cnt <= cfg_cnt + 1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned rand_items;
        int unsigned n_items;
        int unsigned eff;
        int unsigned k;
        logic [pse_pkg::EXP_W-1:0] e;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // queries before any run, then a run at the reset exponent
        push_cmd(pse_pkg::CMD_QUERY, 16'd0);
        push_cmd(pse_pkg::CMD_QUERY, 16'hFFFF);
        push_cmd(pse_pkg::CMD_QUERY, 16'd2);
        push_cmd(pse_pkg::CMD_RUN, 16'($urandom));
        push_cmd(pse_pkg::CMD_QUERY, 16'd0);
        push_cmd(pse_pkg::CMD_QUERY, 16'd1);
        push_cmd(pse_pkg::CMD_QUERY, 16'd2);
        push_cmd(pse_pkg::CMD_QUERY, 16'd3);
        push_cmd(pse_pkg::CMD_QUERY, 16'd4);
        push_cmd(pse_pkg::CMD_QUERY, 16'd65521);
        push_cmd(pse_pkg::CMD_QUERY, 16'd65534);
        push_cmd(pse_pkg::CMD_QUERY, 16'hFFFF);
        push_cmd(pse_pkg::CMD_QUERY, 16'h5555);
        push_cmd(pse_pkg::CMD_QUERY, 16'hAAAA);
        drain();

        // exponent below range saturates low, repeated run
        set_exponent(pse_pkg::EXP_W'(0));
        push_cmd(pse_pkg::CMD_QUERY, 16'd7);
        push_cmd(pse_pkg::CMD_RUN, 16'hFFFF);
        push_cmd(pse_pkg::CMD_QUERY, 16'd5);
        push_cmd(pse_pkg::CMD_QUERY, 16'd6);
        push_cmd(pse_pkg::CMD_QUERY, 16'd7);
        push_cmd(pse_pkg::CMD_RUN, 16'd0);
        push_cmd(pse_pkg::CMD_QUERY, 16'd3);
        drain();

        // exponent above range saturates high
        set_exponent(pse_pkg::EXP_W'(31));
        push_cmd(pse_pkg::CMD_RUN, 16'd0);
        push_cmd(pse_pkg::CMD_QUERY, 16'd65521);
        push_cmd(pse_pkg::CMD_QUERY, 16'd8191);
        drain();

        // random phases: a run at a random exponent, then mostly queries
        rand_items = 0;
        steady = 1'b1;
        while (rand_items < 75)
        begin
            e = pse_pkg::EXP_W'($urandom_range(0, 12));
            eff = (e < pse_pkg::EXP_MIN) ? pse_pkg::EXP_MIN : e;
            set_exponent(e);
            push_cmd(pse_pkg::CMD_RUN, 16'($urandom));
            n_items = $urandom_range(6, 14);
            for (k = 0; k < n_items; k++)
            begin
                if ($urandom_range(0, 99) < 10)
                    push_cmd(pse_pkg::CMD_RUN, 16'($urandom));
                else if ($urandom_range(0, 99) < 75)
                    push_cmd(pse_pkg::CMD_QUERY, 16'($urandom_range(0, (1 << eff) + 1)));
                else
                    push_cmd(pse_pkg::CMD_QUERY, 16'($urandom));
            end
            rand_items += n_items + 1;
            drain();
            steady = 1'b0;
        end

        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
